FILE: rtl/psc_pkg.sv
// Shared types and constants of the polygon shape classifier.
`timescale 1ns / 1ps

package psc_pkg;

  // Vertex count saturates at the top of a five bit counter.
  localparam int COUNT_W = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [COUNT_W-1:0] CORNER_CNT = 5'd4;
  localparam logic [COUNT_W-1:0] N_TRI = 5'd3;
  localparam logic [COUNT_W-1:0] N_QUAD = 5'd4;
  localparam logic [COUNT_W-1:0] N_PENT = 5'd5;
  localparam logic [COUNT_W-1:0] N_HEX = 5'd6;

  // Configuration register map.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROD_TOL = 2'd1;
  localparam int SIDE_TOL_W = 24;
  localparam int PROD_TOL_W = 48;
  localparam logic [SIDE_TOL_W-1:0] SIDE_TOL_RESET = 24'd2000;
  localparam logic [PROD_TOL_W-1:0] PROD_TOL_RESET = 48'd500000;

  // Shape class codes.
  localparam int CLASS_W = 4;
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 4'd0;
  localparam logic [CLASS_W-1:0] CLS_CIRCLE = 4'd1;
  localparam logic [CLASS_W-1:0] CLS_ELLIPSE = 4'd2;
  localparam logic [CLASS_W-1:0] CLS_TRIANGLE = 4'd3;
  localparam logic [CLASS_W-1:0] CLS_SQUARE = 4'd4;
  localparam logic [CLASS_W-1:0] CLS_RHOMBUS = 4'd5;
  localparam logic [CLASS_W-1:0] CLS_RECTANGLE = 4'd6;
  localparam logic [CLASS_W-1:0] CLS_PARALLELOGRAM = 4'd7;
  localparam logic [CLASS_W-1:0] CLS_TRAPEZOID = 4'd8;
  localparam logic [CLASS_W-1:0] CLS_PENTAGON = 4'd9;
  localparam logic [CLASS_W-1:0] CLS_HEXAGON = 4'd10;
  localparam logic [CLASS_W-1:0] CLS_POLYGON = 4'd11;

  // Circle test ratio: 100 * max(w, h) < 105 * min(w, h).
  localparam int CIRC_NUM = 100;
  localparam int CIRC_DEN = 105;

  // Sequencer step counter.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] MUL_STEPS = 4'd14;
  localparam logic [STEP_W-1:0] CMP_LAST = 4'd7;

  // Product pairs: each quantity is the sum or difference of two products.
  localparam int PAIR_W = 3;
  localparam logic [PAIR_W-1:0] PAIR_S1 = 3'd0;
  localparam logic [PAIR_W-1:0] PAIR_S2 = 3'd1;
  localparam logic [PAIR_W-1:0] PAIR_S3 = 3'd2;
  localparam logic [PAIR_W-1:0] PAIR_S4 = 3'd3;
  localparam logic [PAIR_W-1:0] PAIR_CR1 = 3'd4;
  localparam logic [PAIR_W-1:0] PAIR_CR2 = 3'd5;
  localparam logic [PAIR_W-1:0] PAIR_DOT = 3'd6;

  // Tolerance checks, one per compare step; also the flag bit positions.
  localparam int CMP_W = 3;
  localparam logic [CMP_W-1:0] CMP_EQ12 = 3'd0;
  localparam logic [CMP_W-1:0] CMP_EQ23 = 3'd1;
  localparam logic [CMP_W-1:0] CMP_EQ34 = 3'd2;
  localparam logic [CMP_W-1:0] CMP_EQ13 = 3'd3;
  localparam logic [CMP_W-1:0] CMP_EQ24 = 3'd4;
  localparam logic [CMP_W-1:0] CMP_PAR1 = 3'd5;
  localparam logic [CMP_W-1:0] CMP_PAR2 = 3'd6;
  localparam logic [CMP_W-1:0] CMP_RIGHT = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              take;
    logic              diff_en;
    logic              mul_en;
    logic [STEP_W-1:0] mul_sel;
    logic              acc_en;
    logic [STEP_W-1:0] acc_sel;
    logic              cmp_en;
    logic [CMP_W-1:0]  cmp_sel;
    logic              box_en;
    logic              circ_en;
    logic              load_result;
  } psc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_quad;
    logic n_round;
    logic out_free;
  } psc_sts_t;

endpackage

FILE: rtl/psc_vertex_if.sv
// Vertex input channel: valid, ready and one vertex.
`timescale 1ns / 1ps

interface psc_vertex_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          is_final;

  modport source (output valid, output vertex_x, output vertex_y, output is_final,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input is_final,
                output ready);
endinterface

FILE: rtl/psc_class_if.sv
// Result channel: valid, ready and one shape class code.
`timescale 1ns / 1ps

interface psc_class_if;
  logic       valid;
  logic       ready;
  logic [3:0] shape_class;

  modport source (output valid, output shape_class, input ready);
  modport sink (input valid, input shape_class, output ready);
endinterface

FILE: rtl/psc_cfg_if.sv
// Configuration write channel: valid, ready, register index and data.
`timescale 1ns / 1ps

interface psc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/psc_datapath.sv
// Datapath: vertex capture, bounding box, shared multiplier, tolerance checks, result.
`timescale 1ns / 1ps

module psc_datapath #(
  parameter int COORD_WIDTH        = 24,
  parameter int ROUND_VERTEX_LIMIT = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  psc_pkg::psc_cmd_t                    cmd_i,
  output psc_pkg::psc_sts_t                    sts_o,
  input  logic signed [COORD_WIDTH-1:0]        vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0]        vertex_y_i,
  input  logic                                 is_final_i,
  input  logic                                 cfg_valid_i,
  input  logic [psc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [psc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [psc_pkg::CLASS_W-1:0]          shape_class_o
);
  import psc_pkg::*;

  localparam int DW   = COORD_WIDTH + 1;           // coordinate difference
  localparam int VW   = 2 * COORD_WIDTH + 2;       // products and their sums
  localparam int CMPW = (VW + 1 > PROD_TOL_W + 1) ? VW + 1 : PROD_TOL_W + 1;
  localparam int BW   = DW + 7;                    // box extent times 105

  // Configuration registers.
  logic [SIDE_TOL_W-1:0] side_tol_q;
  logic [PROD_TOL_W-1:0] prod_tol_q;

  // Vertex collection state.
  logic [COUNT_W-1:0]            count_q, count_d, count_inc, n_q;
  logic signed [COORD_WIDTH-1:0] cx_q [4];
  logic signed [COORD_WIDTH-1:0] cy_q [4];
  logic signed [COORD_WIDTH-1:0] min_x_q, max_x_q, min_y_q, max_y_q;

  // Quadrilateral evaluation state.
  logic signed [DW-1:0] dx_q [4];
  logic signed [DW-1:0] dy_q [4];
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [VW-1:0] prod_q, acc_q, acc_sum;
  logic signed [VW-1:0] side_q [4];
  logic signed [VW-1:0] cross_q [2];
  logic signed [VW-1:0] dot_q;
  logic [7:0]           flags_q;

  // Tolerance check operands.
  logic signed [CMPW-1:0] cmp_a, cmp_b, cmp_diff, cmp_tol;
  logic                   cmp_below;

  // Bounding box test.
  logic [DW-1:0] w_q, h_q, box_big, box_small;
  logic [BW-1:0] circ_lhs, circ_rhs;
  logic          circ_q;

  // Result.
  logic                 out_valid_q;
  logic [CLASS_W-1:0]   shape_q, class_d;
  logic                 p1, p2, rt, all_eq, opp_eq;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_tol_q <= SIDE_TOL_RESET;
      prod_tol_q <= PROD_TOL_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SIDE_TOL) begin
        side_tol_q <= cfg_data_i[SIDE_TOL_W-1:0];
      end
      if (cfg_index_i == CFG_PROD_TOL) begin
        prod_tol_q <= cfg_data_i[PROD_TOL_W-1:0];
      end
    end
  end

  // Saturating vertex count; the final vertex latches n and restarts the count.
  always_comb begin
    count_inc = (count_q < COUNT_MAX) ? count_q + COUNT_W'(1) : count_q;
    count_d   = is_final_i ? '0 : count_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      n_q     <= '0;
    end else if (cmd_i.take) begin
      count_q <= count_d;
      if (is_final_i) begin
        n_q <= count_inc;
      end
    end
  end

  // First four corners and the running bounding box.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      if (count_q < CORNER_CNT) begin
        cx_q[count_q[1:0]] <= vertex_x_i;
        cy_q[count_q[1:0]] <= vertex_y_i;
      end
      if (count_q == '0) begin
        min_x_q <= vertex_x_i;
        max_x_q <= vertex_x_i;
        min_y_q <= vertex_y_i;
        max_y_q <= vertex_y_i;
      end else begin
        if (vertex_x_i < min_x_q) min_x_q <= vertex_x_i;
        if (vertex_x_i > max_x_q) max_x_q <= vertex_x_i;
        if (vertex_y_i < min_y_q) min_y_q <= vertex_y_i;
        if (vertex_y_i > max_y_q) max_y_q <= vertex_y_i;
      end
    end
  end

  // Side vectors: entry k runs from corner k to corner k+1 (wrapping).
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      for (int k = 0; k < 4; k++) begin
        dx_q[k] <= DW'(cx_q[(k + 1) % 4]) - DW'(cx_q[k]);
        dy_q[k] <= DW'(cy_q[(k + 1) % 4]) - DW'(cy_q[k]);
      end
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = dx_q[0];
    mul_b = dx_q[0];
    unique case (cmd_i.mul_sel[STEP_W-1:1])
      PAIR_S1: begin
        mul_a = cmd_i.mul_sel[0] ? dy_q[0] : dx_q[0];
        mul_b = mul_a;
      end
      PAIR_S2: begin
        mul_a = cmd_i.mul_sel[0] ? dy_q[1] : dx_q[1];
        mul_b = mul_a;
      end
      PAIR_S3: begin
        mul_a = cmd_i.mul_sel[0] ? dy_q[2] : dx_q[2];
        mul_b = mul_a;
      end
      PAIR_S4: begin
        mul_a = cmd_i.mul_sel[0] ? dy_q[3] : dx_q[3];
        mul_b = mul_a;
      end
      PAIR_CR1: begin
        mul_a = cmd_i.mul_sel[0] ? dy_q[0] : dx_q[0];
        mul_b = cmd_i.mul_sel[0] ? dx_q[2] : dy_q[2];
      end
      PAIR_CR2: begin
        mul_a = cmd_i.mul_sel[0] ? dy_q[1] : dx_q[1];
        mul_b = cmd_i.mul_sel[0] ? dx_q[3] : dy_q[3];
      end
      PAIR_DOT: begin
        mul_a = cmd_i.mul_sel[0] ? dy_q[0] : dx_q[0];
        mul_b = cmd_i.mul_sel[0] ? dy_q[1] : dx_q[1];
      end
      default: begin
        mul_a = dx_q[0];
        mul_b = dx_q[0];
      end
    endcase
  end

  // Registered product.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // Cross products subtract the second product, all others add it.
  always_comb begin
    if (cmd_i.acc_sel[STEP_W-1:1] == PAIR_CR1 || cmd_i.acc_sel[STEP_W-1:1] == PAIR_CR2) begin
      acc_sum = acc_q - prod_q;
    end else begin
      acc_sum = acc_q + prod_q;
    end
  end

  // Pair accumulation into the named quantities.
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      if (!cmd_i.acc_sel[0]) begin
        acc_q <= prod_q;
      end else begin
        unique case (cmd_i.acc_sel[STEP_W-1:1])
          PAIR_S1:  side_q[0]  <= acc_sum;
          PAIR_S2:  side_q[1]  <= acc_sum;
          PAIR_S3:  side_q[2]  <= acc_sum;
          PAIR_S4:  side_q[3]  <= acc_sum;
          PAIR_CR1: cross_q[0] <= acc_sum;
          PAIR_CR2: cross_q[1] <= acc_sum;
          PAIR_DOT: dot_q      <= acc_sum;
          default:  acc_q      <= acc_q;
        endcase
      end
    end
  end

  // Shared tolerance check: |a - b| < tol.
  always_comb begin
    cmp_a   = CMPW'(side_q[0]);
    cmp_b   = '0;
    cmp_tol = CMPW'(side_tol_q);
    unique case (cmd_i.cmp_sel)
      CMP_EQ12: begin
        cmp_a = CMPW'(side_q[0]);
        cmp_b = CMPW'(side_q[1]);
      end
      CMP_EQ23: begin
        cmp_a = CMPW'(side_q[1]);
        cmp_b = CMPW'(side_q[2]);
      end
      CMP_EQ34: begin
        cmp_a = CMPW'(side_q[2]);
        cmp_b = CMPW'(side_q[3]);
      end
      CMP_EQ13: begin
        cmp_a = CMPW'(side_q[0]);
        cmp_b = CMPW'(side_q[2]);
      end
      CMP_EQ24: begin
        cmp_a = CMPW'(side_q[1]);
        cmp_b = CMPW'(side_q[3]);
      end
      CMP_PAR1: begin
        cmp_a   = CMPW'(cross_q[0]);
        cmp_tol = CMPW'(prod_tol_q);
      end
      CMP_PAR2: begin
        cmp_a   = CMPW'(cross_q[1]);
        cmp_tol = CMPW'(prod_tol_q);
      end
      CMP_RIGHT: begin
        cmp_a   = CMPW'(dot_q);
        cmp_tol = CMPW'(prod_tol_q);
      end
      default: begin
        cmp_a = CMPW'(side_q[0]);
      end
    endcase
    cmp_diff  = cmp_a - cmp_b;
    cmp_below = (cmp_diff < cmp_tol) && (cmp_diff > -cmp_tol);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      flags_q[cmd_i.cmp_sel] <= cmp_below;
    end
  end

  // Bounding box extents, then the near-round test.
  always_ff @(posedge clk_i) begin
    if (cmd_i.box_en) begin
      w_q <= DW'(max_x_q) - DW'(min_x_q);
      h_q <= DW'(max_y_q) - DW'(min_y_q);
    end
  end

  always_comb begin
    box_big   = (w_q > h_q) ? w_q : h_q;
    box_small = (w_q > h_q) ? h_q : w_q;
    circ_lhs  = BW'(box_big) * BW'(CIRC_NUM);
    circ_rhs  = BW'(box_small) * BW'(CIRC_DEN);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.circ_en) begin
      circ_q <= circ_lhs < circ_rhs;
    end
  end

  // Class decision from the vertex count and the evaluated flags.
  always_comb begin
    p1     = flags_q[CMP_PAR1];
    p2     = flags_q[CMP_PAR2];
    rt     = flags_q[CMP_RIGHT];
    all_eq = flags_q[CMP_EQ12] && flags_q[CMP_EQ23] && flags_q[CMP_EQ34];
    opp_eq = flags_q[CMP_EQ13] && flags_q[CMP_EQ24];
    priority if (n_q < N_TRI) begin
      class_d = CLS_UNKNOWN;
    end else if (n_q > COUNT_W'(ROUND_VERTEX_LIMIT)) begin
      class_d = circ_q ? CLS_CIRCLE : CLS_ELLIPSE;
    end else if (n_q == N_TRI) begin
      class_d = CLS_TRIANGLE;
    end else if (n_q == N_QUAD) begin
      priority if (p1 && p2 && all_eq) begin
        class_d = rt ? CLS_SQUARE : CLS_RHOMBUS;
      end else if (p1 && p2 && opp_eq) begin
        class_d = rt ? CLS_RECTANGLE : CLS_PARALLELOGRAM;
      end else if (p1 || p2) begin
        class_d = CLS_TRAPEZOID;
      end else begin
        class_d = CLS_POLYGON;
      end
    end else if (n_q == N_PENT) begin
      class_d = CLS_PENTAGON;
    end else if (n_q == N_HEX) begin
      class_d = CLS_HEXAGON;
    end else begin
      class_d = CLS_POLYGON;
    end
  end

  // Output register; it holds the class until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      shape_q <= class_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign shape_class_o  = shape_q;
  assign sts_o.n_quad   = (n_q == N_QUAD);
  assign sts_o.n_round  = (n_q > COUNT_W'(ROUND_VERTEX_LIMIT));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

FILE: rtl/psc_controller.sv
// Controller: sequences vertex collection, quadrilateral evaluation and result hand-off.
`timescale 1ns / 1ps

module psc_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_final_i,
  output logic              in_ready_o,
  input  psc_pkg::psc_sts_t sts_i,
  output psc_pkg::psc_cmd_t cmd_o
);
  import psc_pkg::*;

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_DECIDE  = 3'd1;
  localparam logic [2:0] ST_DIFF    = 3'd2;
  localparam logic [2:0] ST_MUL     = 3'd3;
  localparam logic [2:0] ST_CMP     = 3'd4;
  localparam logic [2:0] ST_BOX     = 3'd5;
  localparam logic [2:0] ST_CIRC    = 3'd6;
  localparam logic [2:0] ST_RESULT  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  // Next state, step counter and commands.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mul_sel = step_q;
    cmd_o.acc_sel = step_q - STEP_W'(1);
    cmd_o.cmp_sel = step_q[CMP_W-1:0];
    unique case (state_q)
      ST_COLLECT: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && in_final_i) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        step_d = '0;
        priority if (sts_i.n_quad) begin
          state_d = ST_DIFF;
        end else if (sts_i.n_round) begin
          state_d = ST_BOX;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        // Multiply at step k while accumulating the product of step k-1.
        cmd_o.mul_en = (step_q < MUL_STEPS);
        cmd_o.acc_en = (step_q != '0);
        if (step_q == MUL_STEPS) begin
          step_d  = '0;
          state_d = ST_CMP;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_CMP: begin
        cmd_o.cmp_en = 1'b1;
        if (step_q == CMP_LAST) begin
          step_d  = '0;
          state_d = ST_RESULT;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_BOX: begin
        cmd_o.box_en = 1'b1;
        state_d      = ST_CIRC;
      end
      ST_CIRC: begin
        cmd_o.circ_en = 1'b1;
        state_d       = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_COLLECT;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

FILE: rtl/polygon_shape_classifier.sv
// Top level of the polygon shape classifier.
//
// Usage: vertices of one closed polygon arrive on vertex_i, one transaction per
// vertex, the last one with is_final set. Non-final vertices are taken one per
// cycle. After a final vertex the block stops taking vertices and classifies:
// a count above the round limit from its bounding box extents and the circle
// test, a quadrilateral from its side vectors, where a single shared
// multiplier forms the 14 products of side lengths, cross and dot products
// and one shared unit then runs 8 tolerance checks, and any other count from
// the count alone; the class waits for free output. The next polygon's first
// vertex is taken in the cycle after the class is loaded. The class sits in an
// output register, so a stalled receiver holds only a following final vertex;
// non-final vertices keep streaming in. Configuration writes on cfg_i are
// always ready and take effect at once; write them only while idle.
// Reset clears the vertex count, the sequencer and the output valid, and loads
// the tolerance registers with their defaults.
`timescale 1ns / 1ps

module polygon_shape_classifier #(
  parameter int COORD_WIDTH        = 24,
  parameter int ROUND_VERTEX_LIMIT = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  psc_vertex_if.sink vertex_i,
  psc_class_if.source class_o,
  psc_cfg_if.sink    cfg_i
);
  import psc_pkg::*;

  psc_cmd_t cmd;
  psc_sts_t sts;

  // Configuration writes never stall.
  assign cfg_i.ready = 1'b1;

  psc_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vertex_i.valid),
    .in_final_i (vertex_i.is_final),
    .in_ready_o (vertex_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psc_datapath #(
    .COORD_WIDTH        (COORD_WIDTH),
    .ROUND_VERTEX_LIMIT (ROUND_VERTEX_LIMIT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .vertex_x_i    (vertex_i.vertex_x),
    .vertex_y_i    (vertex_i.vertex_y),
    .is_final_i    (vertex_i.is_final),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .out_ready_i   (class_o.ready),
    .out_valid_o   (class_o.valid),
    .shape_class_o (class_o.shape_class)
  );

endmodule

FILE: rtl/psc_checker.sv
// Port-level checks of the polygon shape classifier, bound to the top level.
`timescale 1ns / 1ps

module psc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_final_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] shape_class_i
);
  import psc_pkg::*;

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(shape_class_i))
    else $error("result dropped or changed while stalled");

  // After a final vertex the block is busy classifying.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_final_i |=> !in_ready_i)
    else $error("vertex taken right after a final vertex");

  // A new result is only loaded while vertex intake is paused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while vertices were being collected");

  // Only defined class codes are delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> shape_class_i <= CLS_POLYGON)
    else $error("undefined shape class code");

endmodule

bind polygon_shape_classifier psc_checker u_psc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (vertex_i.valid),
  .in_ready_i    (vertex_i.ready),
  .in_final_i    (vertex_i.is_final),
  .out_valid_i   (class_o.valid),
  .out_ready_i   (class_o.ready),
  .shape_class_i (class_o.shape_class)
);
